[rtl/pvd_pkg.sv]
// Package for the packed varint decoder: shared constants, codes and types.
// No dependencies; imported by every rtl module and the checker.
package pvd_pkg;

    localparam int MAX_VARINT_BYTES = 10;
    localparam int POS_W            = 4;
    localparam int COUNT_W          = 16;
    localparam int VALUE_W          = 64;
    localparam int QUEUE_DEPTH_DEF  = 2;

    localparam logic [POS_W-1:0]   LAST_POS       = POS_W'(MAX_VARINT_BYTES - 1);
    localparam logic [COUNT_W-1:0] MAX_VALUES_RST = 16'hFFFF;

    // result status codes
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_TOO_LONG  = 2'd1;
    localparam logic [1:0] ST_UNTERM    = 2'd2;
    localparam logic [1:0] ST_TOO_MANY  = 2'd3;

    // what the back end does with a queued item
    typedef enum logic [1:0] {
        KIND_CONT = 2'd0,   // merge payload, no result
        KIND_VAL  = 2'd1,   // merge payload, emit finished value
        KIND_ERR  = 2'd2    // emit error, drop partial value
    } t_kind;

    typedef struct packed {
        t_kind              kind;
        logic               last;
        logic [6:0]         payload;
        logic [POS_W-1:0]   pos;
        logic [1:0]         status;
        logic [COUNT_W-1:0] count;
    } t_op;

    typedef struct packed {
        logic [VALUE_W-1:0] value;
        logic               has_value;
        logic               buffer_done;
        logic [1:0]         status;
        logic [COUNT_W-1:0] value_count;
    } t_result;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

endpackage

[rtl/pvd_fifo.sv]
// Small register-based queue, used between front and back and at the output.
// Depends on pvd_pkg (t_q_status).
module pvd_fifo
    import pvd_pkg::*;
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_rdata,
    output t_q_status        o_status
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wr, n_wr;
    logic [AW-1:0]    r_rd, n_rd;
    logic [CW-1:0]    r_cnt, n_cnt;

    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (i_push) begin
            n_wr = (r_wr == AW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
        end
        if (i_pop) begin
            n_rd = (r_rd == AW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (!i_push && i_pop) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_wdata;
        end
    end

    assign o_rdata        = r_mem[r_rd];
    assign o_status.full  = (r_cnt == CW'(DEPTH));
    assign o_status.empty = (r_cnt == '0);

endmodule

[rtl/pvd_front.sv]
// Front end: accepts bytes, tracks varint position, value count and discard
// state, and classifies each byte into a queued op. Depends on pvd_pkg.
module pvd_front
    import pvd_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [COUNT_W-1:0] i_cfg_data,
    input  logic               i_accept,
    input  logic [7:0]         i_data_byte,
    input  logic               i_last_byte,
    output logic               o_push,
    output t_op                o_op
);

    logic [COUNT_W-1:0] r_max;
    logic [POS_W-1:0]   r_pos, n_pos;
    logic [COUNT_W-1:0] r_count, n_count;
    logic               r_discard, n_discard;

    always_comb begin
        n_pos     = r_pos;
        n_count   = r_count;
        n_discard = r_discard;
        o_push    = 1'b0;
        o_op.kind    = KIND_CONT;
        o_op.last    = i_last_byte;
        o_op.payload = i_data_byte[6:0];
        o_op.pos     = r_pos;
        o_op.status  = ST_OK;
        o_op.count   = r_count;

        if (i_accept) begin
            if (r_discard) begin
                // swallow the rest of a failed buffer
                if (i_last_byte) begin
                    n_pos     = '0;
                    n_count   = '0;
                    n_discard = 1'b0;
                end
            end else begin
                o_push = 1'b1;
                if (r_pos == '0 && r_count >= r_max) begin
                    o_op.kind   = KIND_ERR;
                    o_op.status = ST_TOO_MANY;
                end else if (!i_data_byte[7]) begin
                    o_op.kind  = KIND_VAL;
                    o_op.count = r_count + 1'b1;
                    n_pos      = '0;
                    n_count    = i_last_byte ? '0 : r_count + 1'b1;
                end else if (r_pos == LAST_POS) begin
                    o_op.kind   = KIND_ERR;
                    o_op.status = ST_TOO_LONG;
                end else if (i_last_byte) begin
                    o_op.kind   = KIND_ERR;
                    o_op.status = ST_UNTERM;
                end else begin
                    n_pos = r_pos + 1'b1;
                end

                if (o_op.kind == KIND_ERR) begin
                    n_pos = '0;
                    if (i_last_byte) begin
                        n_count = '0;
                    end else begin
                        n_discard = 1'b1;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max     <= MAX_VALUES_RST;
            r_pos     <= '0;
            r_count   <= '0;
            r_discard <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_max <= i_cfg_data;
            end
            r_pos     <= n_pos;
            r_count   <= n_count;
            r_discard <= n_discard;
        end
    end

endmodule

[rtl/pvd_back.sv]
// Back end: merges 7-bit groups into the 64-bit accumulator and builds
// result items from queued ops. Depends on pvd_pkg.
module pvd_back
    import pvd_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_op       i_op,
    input  t_q_status i_op_status,
    input  t_q_status i_res_status,
    output logic      o_pop,
    output logic      o_push,
    output t_result   o_result
);

    logic [VALUE_W-1:0] r_acc, n_acc;
    logic [5:0]         shamt;
    logic [VALUE_W-1:0] merged;

    // 7 * pos; groups past bit 63 fall off the top
    assign shamt  = 6'({i_op.pos, 3'b000} - {3'b000, i_op.pos});
    assign merged = r_acc | ({{(VALUE_W-7){1'b0}}, i_op.payload} << shamt);

    always_comb begin
        o_pop  = !i_op_status.empty && (i_op.kind == KIND_CONT || !i_res_status.full);
        o_push = 1'b0;
        n_acc  = r_acc;
        o_result.value       = '0;
        o_result.has_value   = 1'b0;
        o_result.buffer_done = 1'b1;
        o_result.status      = i_op.status;
        o_result.value_count = i_op.count;
        if (o_pop) begin
            case (i_op.kind)
                KIND_CONT: begin
                    n_acc = merged;
                end
                KIND_VAL: begin
                    o_push               = 1'b1;
                    o_result.value       = merged;
                    o_result.has_value   = 1'b1;
                    o_result.buffer_done = i_op.last;
                    o_result.status      = ST_OK;
                    n_acc                = '0;
                end
                KIND_ERR: begin
                    o_push = 1'b1;
                    n_acc  = '0;
                end
                default: begin
                    n_acc = r_acc;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc <= '0;
        end else begin
            r_acc <= n_acc;
        end
    end

endmodule

[rtl/packed_varint_decoder.sv]
// Top level of the packed varint decoder.
// Depends on pvd_pkg, pvd_front, pvd_fifo and pvd_back.
//
// Decodes unsigned little-endian base-128 varints from a packed buffer fed
// one byte per item (push/full). Each byte's low 7 bits go to bit 7*p of the
// value, p being the byte's place in the varint; a byte with bit 7 clear ends
// the varint and yields a result (empty/pop) with the value and the running
// count for the buffer. In a tenth byte only bit 0 lands (bit 63). Errors end
// a buffer early with buffer_done set: status 1 for a tenth byte with bit 7
// set, 2 for a buffer whose last byte still has bit 7 set, 3 when a new varint
// would exceed max_values. After an error the remaining bytes of that buffer
// are swallowed without results, up to and including the last byte.
// Rate: one byte per cycle sustained while full is low; the front end's
// position/count update and the back end's accumulator shift-or are
// combinational. A result passes through two registered queues: the byte
// enters the op queue when taken, and the back end writes the result queue
// as it pops that op, stalling while the result queue is full. Both queues
// are QUEUE_DEPTH entries; while results wait, continuation bytes still
// drain into the accumulator, and full rises once a value or error op is
// held at the head of a full op queue. max_values (reset 65535) is written
// through i_cfg_we / i_cfg_data; the user must write it only while the
// block is idle; the block does not enforce it. Applies at next varint start.
module packed_varint_decoder
    import pvd_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [COUNT_W-1:0] i_cfg_data,
    input  logic               push,
    output logic               full,
    input  logic [7:0]         i_data_byte,
    input  logic               i_last_byte,
    output logic               empty,
    input  logic               pop,
    output logic [VALUE_W-1:0] o_value,
    output logic               o_has_value,
    output logic               o_buffer_done,
    output logic [1:0]         o_status,
    output logic [COUNT_W-1:0] o_value_count
);

    t_q_status op_status;
    t_q_status res_status;
    logic      front_push;
    t_op       front_op;
    t_op       back_op;
    logic      back_pop;
    logic      back_push;
    t_result   back_result;
    t_result   head;

    // input side stalls only when the op queue is full
    assign full = op_status.full;

    pvd_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_data  (i_cfg_data),
        .i_accept    (push && !full),
        .i_data_byte (i_data_byte),
        .i_last_byte (i_last_byte),
        .o_push      (front_push),
        .o_op        (front_op)
    );

    // classified bytes waiting for the back end
    pvd_fifo #(
        .WIDTH ($bits(t_op)),
        .DEPTH (QUEUE_DEPTH)
    ) u_op_q (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (front_push),
        .i_wdata  (front_op),
        .i_pop    (back_pop),
        .o_rdata  (back_op),
        .o_status (op_status)
    );

    pvd_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_op         (back_op),
        .i_op_status  (op_status),
        .i_res_status (res_status),
        .o_pop        (back_pop),
        .o_push       (back_push),
        .o_result     (back_result)
    );

    // finished results; the head is what the port shows
    pvd_fifo #(
        .WIDTH ($bits(t_result)),
        .DEPTH (QUEUE_DEPTH)
    ) u_res_q (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (back_push),
        .i_wdata  (back_result),
        .i_pop    (pop && !empty),
        .o_rdata  (head),
        .o_status (res_status)
    );

    assign empty         = res_status.empty;
    assign o_value       = head.value;
    assign o_has_value   = head.has_value;
    assign o_buffer_done = head.buffer_done;
    assign o_status      = head.status;
    assign o_value_count = head.value_count;

endmodule

[rtl/pvd_checker.sv]
// Port-level checker for the packed varint decoder, bound to the top level.
// Depends on pvd_pkg and packed_varint_decoder.
module pvd_port_checker
    import pvd_pkg::*;
(
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               full,
    input logic               empty,
    input logic [VALUE_W-1:0] o_value,
    input logic               o_has_value,
    input logic               o_buffer_done,
    input logic [1:0]         o_status
);

    // both queues come out of reset drained
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> (empty && !full))
        else $error("queues not drained after reset");

    a_value_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_has_value) |-> (o_status == ST_OK))
        else $error("value result with error status");

    a_err_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_status != ST_OK) |-> (o_buffer_done && !o_has_value))
        else $error("error result must end buffer without value");

    a_no_value_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !o_has_value) |-> (o_value == '0))
        else $error("non-value result carries nonzero value");

endmodule

bind packed_varint_decoder pvd_port_checker u_pvd_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .full          (full),
    .empty         (empty),
    .o_value       (o_value),
    .o_has_value   (o_has_value),
    .o_buffer_done (o_buffer_done),
    .o_status      (o_status)
);
